FILE: rtl/core/biallelic_site_dxy_defines.svh
// Assertion macros shared by the biallelic site dxy checker files.
// Depends on nothing; included by bare file name.
`ifndef BIALLELIC_SITE_DXY_DEFINES_SVH
`define BIALLELIC_SITE_DXY_DEFINES_SVH

// clocked check, masked while reset is asserted
`define BSD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define BSD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/bsd_pkg.sv
// Shared widths, constants and beat types for the biallelic site dxy pipeline.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package bsd_pkg;

    localparam int COUNT_BITS      = 16;
    localparam int FRAC_BITS       = 16;
    localparam int ALLELES         = 6;
    localparam int IDX_BITS        = 3;
    localparam int NZ_BITS         = $clog2(ALLELES + 1);
    localparam int TOT_BITS        = COUNT_BITS + $clog2(ALLELES);
    localparam int REM_BITS        = TOT_BITS + 1;
    localparam int Q_BITS          = FRAC_BITS + 1;
    localparam int DIV_STEPS       = Q_BITS;
    localparam int STEPS_PER_STAGE = 2;
    localparam int DIV_STAGES      = (DIV_STEPS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
    localparam int QW_BITS         = DIV_STAGES * STEPS_PER_STAGE;
    localparam int Q_PAD           = QW_BITS - DIV_STEPS;
    localparam int PROD_BITS       = 2 * Q_BITS;
    localparam int ACC_BITS        = PROD_BITS + 1;

    localparam logic [Q_BITS-1:0]   FRAC_ONE    = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [IDX_BITS-1:0] ALLELE_LAST = IDX_BITS'(ALLELES - 1);

    typedef logic [COUNT_BITS-1:0] count_t;

    typedef struct packed {
        count_t pop1_count_a;
        count_t pop1_count_t;
        count_t pop1_count_c;
        count_t pop1_count_g;
        count_t pop1_count_n;
        count_t pop1_count_indel;
        count_t pop2_count_a;
        count_t pop2_count_t;
        count_t pop2_count_c;
        count_t pop2_count_g;
        count_t pop2_count_n;
        count_t pop2_count_indel;
    } site_t;

    typedef struct packed {
        logic [Q_BITS-1:0]   dxy_value;
        logic [IDX_BITS-1:0] allele_index;
    } result_t;

    typedef struct packed {
        logic [REM_BITS-1:0] rem;
        logic [TOT_BITS-1:0] tot;
        logic [QW_BITS-1:0]  quo;
    } div_lane_t;

    typedef struct packed {
        div_lane_t           pop1;
        div_lane_t           pop2;
        logic [IDX_BITS-1:0] allele_index;
    } div_data_t;

    typedef struct packed {
        logic [PROD_BITS-1:0] prod1;
        logic [PROD_BITS-1:0] prod2;
        logic [IDX_BITS-1:0]  allele_index;
    } prod_t;

endpackage

`default_nettype wire

FILE: rtl/core/biallelic_site_dxy.sv
// Top level of the per-site dxy pipeline: front stage, divider chain, product back end.
// Depends on bsd_pkg, bsd_front, bsd_div_stage and bsd_dxy.
//
//   channel   signals                              dir   beat
//   site      site_valid / site_ready / site       in    twelve allele counts
//   result    result_valid / result_ready / result out   dxy_value, allele_index
//
// One site enters per cycle unless a result stall has filled every stage; a site passes the
// front stage, DIV_STAGES divider stages at two quotient bits per stage, then the product and result registers.
// Sites that fail the allele filter are dropped in the front stage.
// rst_n clears every stage valid asynchronously; payload registers are not reset.
// Each stage stalls only while it holds a beat that the next one cannot take,
// so bubbles close up; a waiting result holds off new sites only once every stage is full.
`default_nettype none

module biallelic_site_dxy (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             site_valid,
    output logic             site_ready,
    input  bsd_pkg::site_t   site,
    output logic             result_valid,
    input  logic             result_ready,
    output bsd_pkg::result_t result
);
    import bsd_pkg::*;

    logic      stg_valid [DIV_STAGES+1];
    logic      stg_ready [DIV_STAGES+1];
    div_data_t stg_data  [DIV_STAGES+1];

    bsd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (site_valid),
        .in_ready  (site_ready),
        .in_data   (site),
        .out_valid (stg_valid[0]),
        .out_ready (stg_ready[0]),
        .out_data  (stg_data[0])
    );

    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_div
        bsd_div_stage u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stg_valid[g]),
            .in_ready  (stg_ready[g]),
            .in_data   (stg_data[g]),
            .out_valid (stg_valid[g+1]),
            .out_ready (stg_ready[g+1]),
            .out_data  (stg_data[g+1])
        );
    end

    bsd_dxy u_dxy (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (stg_valid[DIV_STAGES]),
        .in_ready  (stg_ready[DIV_STAGES]),
        .in_data   (stg_data[DIV_STAGES]),
        .out_valid (result_valid),
        .out_ready (result_ready),
        .out_data  (result)
    );

endmodule

`default_nettype wire

FILE: rtl/core/bsd_front.sv
// Front stage: population totals, nonzero allele counts, site filter, allele pick.
// Depends on bsd_pkg; feeds the first divider stage.
`default_nettype none

module bsd_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  bsd_pkg::site_t    in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output bsd_pkg::div_data_t out_data
);
    import bsd_pkg::*;

    count_t                cnt1 [ALLELES];
    count_t                cnt2 [ALLELES];
    logic [TOT_BITS-1:0]   tot1;
    logic [TOT_BITS-1:0]   tot2;
    logic [NZ_BITS-1:0]    nz1;
    logic [NZ_BITS-1:0]    nz2;
    count_t                sel1;
    count_t                sel2;
    logic [IDX_BITS-1:0]   sel_idx;
    logic                  keep;
    logic                  valid_reg;
    div_data_t             data_reg;
    div_data_t             data_next;

    always_comb
    begin
        cnt1[0] = in_data.pop1_count_a;
        cnt1[1] = in_data.pop1_count_t;
        cnt1[2] = in_data.pop1_count_c;
        cnt1[3] = in_data.pop1_count_g;
        cnt1[4] = in_data.pop1_count_n;
        cnt1[5] = in_data.pop1_count_indel;
        cnt2[0] = in_data.pop2_count_a;
        cnt2[1] = in_data.pop2_count_t;
        cnt2[2] = in_data.pop2_count_c;
        cnt2[3] = in_data.pop2_count_g;
        cnt2[4] = in_data.pop2_count_n;
        cnt2[5] = in_data.pop2_count_indel;
    end

    always_comb
    begin
        tot1    = '0;
        tot2    = '0;
        nz1     = '0;
        nz2     = '0;
        sel1    = '0;
        sel2    = '0;
        sel_idx = '0;
        for (int i = 0; i < ALLELES; i++)
        begin
            tot1 = tot1 + TOT_BITS'(cnt1[i]);
            tot2 = tot2 + TOT_BITS'(cnt2[i]);
            nz1  = nz1 + NZ_BITS'(cnt1[i] != '0);
            nz2  = nz2 + NZ_BITS'(cnt2[i] != '0);
        end
        // first allele nonzero in either population wins
        for (int i = ALLELES - 1; i >= 0; i--)
        begin
            if ((cnt1[i] != '0) || (cnt2[i] != '0))
            begin
                sel1    = cnt1[i];
                sel2    = cnt2[i];
                sel_idx = IDX_BITS'(i);
            end
        end
    end

    always_comb
    begin
        keep = (nz1 != '0) && (nz2 != '0)
            && (nz1 <= NZ_BITS'(2)) && (nz2 <= NZ_BITS'(2))
            && !((nz1 == NZ_BITS'(1)) && (nz2 == NZ_BITS'(1)));
    end

    always_comb
    begin
        data_next.pop1.rem     = REM_BITS'(sel1);
        data_next.pop1.tot     = tot1;
        data_next.pop1.quo     = '0;
        data_next.pop2.rem     = REM_BITS'(sel2);
        data_next.pop2.tot     = tot2;
        data_next.pop2.quo     = '0;
        data_next.allele_index = sel_idx;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid && keep;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

FILE: rtl/core/bsd_div_stage.sv
// One stage of the pipelined restoring divider; both frequencies advance together.
// Depends on bsd_pkg; chained in the top level.
`default_nettype none

module bsd_div_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  bsd_pkg::div_data_t in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output bsd_pkg::div_data_t out_data
);
    import bsd_pkg::*;

    logic      valid_reg;
    div_data_t data_reg;
    div_data_t data_next;

    // compare, subtract, shift in one quotient bit
    function automatic div_lane_t div_step(input div_lane_t l);
        logic                ge;
        logic [REM_BITS-1:0] diff;
        logic [REM_BITS-1:0] kept;
        div_lane_t           r;
        ge    = l.rem >= REM_BITS'(l.tot);
        diff  = l.rem - REM_BITS'(l.tot);
        kept  = ge ? diff : l.rem;
        r.tot = l.tot;
        r.quo = {l.quo[QW_BITS-2:0], ge};
        r.rem = {kept[REM_BITS-2:0], 1'b0};
        return r;
    endfunction

    always_comb
    begin
        data_next = in_data;
        for (int s = 0; s < STEPS_PER_STAGE; s++)
        begin
            data_next.pop1 = div_step(data_next.pop1);
            data_next.pop2 = div_step(data_next.pop2);
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

FILE: rtl/core/bsd_dxy.sv
// Back end: two cross products in one stage, their sum and rescale in the next.
// Depends on bsd_pkg; takes the last divider stage, drives the result beat.
`default_nettype none

module bsd_dxy (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  bsd_pkg::div_data_t in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output bsd_pkg::result_t   out_data
);
    import bsd_pkg::*;

    logic [Q_BITS-1:0]   p1;
    logic [Q_BITS-1:0]   p2;
    prod_t               prod_next;
    prod_t               prod_reg;
    logic                prod_valid_reg;
    logic                prod_ready;
    logic [ACC_BITS-1:0] acc;
    result_t             res_next;
    result_t             res_reg;
    logic                res_valid_reg;

    // drop the padding bits of the divider
    assign p1 = in_data.pop1.quo[QW_BITS-1:Q_PAD];
    assign p2 = in_data.pop2.quo[QW_BITS-1:Q_PAD];

    always_comb
    begin
        prod_next.prod1        = PROD_BITS'(p1) * PROD_BITS'(FRAC_ONE - p2);
        prod_next.prod2        = PROD_BITS'(FRAC_ONE - p1) * PROD_BITS'(p2);
        prod_next.allele_index = in_data.allele_index;
    end

    always_comb
    begin
        acc                   = ACC_BITS'(prod_reg.prod1) + ACC_BITS'(prod_reg.prod2);
        res_next.dxy_value    = acc[FRAC_BITS+Q_BITS-1:FRAC_BITS];
        res_next.allele_index = prod_reg.allele_index;
    end

    assign prod_ready = !res_valid_reg || out_ready;
    assign in_ready   = !prod_valid_reg || prod_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                prod_valid_reg <= in_valid;
            end
            if (prod_ready)
            begin
                res_valid_reg <= prod_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            prod_reg <= prod_next;
        end
        if (prod_ready && prod_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = res_valid_reg;
    assign out_data  = res_reg;

endmodule

`default_nettype wire

FILE: rtl/core/bsd_checker.sv
// Port-level checks for biallelic_site_dxy, attached by bind.
// Depends on bsd_pkg and biallelic_site_dxy_defines.svh.
`default_nettype none
`include "biallelic_site_dxy_defines.svh"

module bsd_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             result_valid,
    input logic             result_ready,
    input bsd_pkg::result_t result
);
    import bsd_pkg::*;

    `BSD_ASSERT(a_hold_valid, clk, rst_n,
        result_valid && !result_ready |=> result_valid, "result beat dropped under stall")
    `BSD_ASSERT(a_hold_data, clk, rst_n,
        result_valid && !result_ready |=> $stable(result), "result beat changed under stall")
    `BSD_ASSERT(a_dxy_range, clk, rst_n,
        result_valid |-> result.dxy_value <= FRAC_ONE, "dxy above one")
    `BSD_ASSERT(a_idx_range, clk, rst_n,
        result_valid |-> result.allele_index <= ALLELE_LAST, "allele index out of range")
    `BSD_ASSERT_ALWAYS(a_reset_idle, clk,
        !rst_n |=> !result_valid, "result valid during reset")

endmodule

bind biallelic_site_dxy bsd_checker u_bsd_checker (.*);

`default_nettype wire

FILE: tb/sv/biallelic_site_dxy_test.sv
`timescale 1ns / 100ps
// Self-checking bench for biallelic_site_dxy: directed and random sites, predicted
// in a scoreboard class and compared beat by beat. Depends on bsd_pkg and the DUT.

module biallelic_site_dxy_test;

    import bsd_pkg::*;

    localparam int POP_BITS     = ALLELES * COUNT_BITS;
    localparam int SITE_BITS    = $bits(site_t);
    localparam int LATENCY      = DIV_STAGES + 3;
    localparam int RANDOM_SITES = 1700;
    localparam int CYCLE_LIMIT  = 400000;

    class site_dxy_tracker;
        result_t pending_dxy [$];
        int      fails   = 0;
        int      kept    = 0;
        int      dropped = 0;
        int      checked = 0;

        task report_mismatch(input string what, input longint unsigned got,
                             input longint unsigned want);
            $display("MISMATCH %s: got %0d, want %0d", what, got, want);
            fails++;
        endtask

        function bit predict_dxy(input site_t s, output result_t r);
            logic [SITE_BITS-1:0] raw;
            longint unsigned      c1 [ALLELES];
            longint unsigned      c2 [ALLELES];
            longint unsigned      t1, t2, f1, f2, one, dxy;
            int                   n1, n2, pick;
            raw  = s;
            one  = 64'd1 << FRAC_BITS;
            t1   = 0;
            t2   = 0;
            n1   = 0;
            n2   = 0;
            pick = -1;
            r    = '0;
            for (int i = 0; i < ALLELES; i++)
            begin
                c1[i] = raw[SITE_BITS-1-COUNT_BITS*i -: COUNT_BITS];
                c2[i] = raw[POP_BITS-1-COUNT_BITS*i -: COUNT_BITS];
                t1 += c1[i];
                t2 += c2[i];
                n1 += (c1[i] != 0);
                n2 += (c2[i] != 0);
            end
            if (n1 == 0 || n2 == 0 || n1 > 2 || n2 > 2 || (n1 == 1 && n2 == 1))
                return 1'b0;
            for (int i = ALLELES - 1; i >= 0; i--)
                if (c1[i] != 0 || c2[i] != 0)
                    pick = i;
            f1  = (c1[pick] == 0) ? 0 : (c1[pick] << FRAC_BITS) / t1;
            f2  = (c2[pick] == 0) ? 0 : (c2[pick] << FRAC_BITS) / t2;
            dxy = (f1 * (one - f2) + (one - f1) * f2) >> FRAC_BITS;
            r.dxy_value    = dxy[Q_BITS-1:0];
            r.allele_index = pick[IDX_BITS-1:0];
            return 1'b1;
        endfunction

        function void note_site(input site_t s);
            result_t r;
            if (predict_dxy(s, r))
            begin
                pending_dxy.push_back(r);
                kept++;
            end
            else
                dropped++;
        endfunction

        task check_result(input result_t got);
            result_t want;
            if (pending_dxy.size() == 0)
            begin
                report_mismatch("result beat with nothing pending", got, 0);
                return;
            end
            want = pending_dxy.pop_front();
            checked++;
            if (got.dxy_value !== want.dxy_value)
                report_mismatch("dxy_value", got.dxy_value, want.dxy_value);
            if (got.allele_index !== want.allele_index)
                report_mismatch("allele_index", got.allele_index, want.allele_index);
        endtask

        function int pending_count();
            return pending_dxy.size();
        endfunction
    endclass

    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    site_valid   = 1'b0;
    logic    site_ready;
    site_t   site         = '0;
    logic    result_valid;
    logic    result_ready = 1'b0;
    result_t result;

    site_dxy_tracker sb;
    int              idle_odds  = 0;
    int              stall_left = 0;
    int              cycles     = 0;
    int              directed   = 0;

    biallelic_site_dxy dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .site_valid   (site_valid),
        .site_ready   (site_ready),
        .site         (site),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    // receiver: random stall bursts
    always @(posedge clk)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else
        begin
            if (stall_left == 0 && idle_odds != 0 && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 9);
            if (stall_left > 0)
            begin
                result_ready <= 1'b0;
                stall_left--;
            end
            else
                result_ready <= 1'b1;
        end
    end

    always @(posedge clk)
        if (rst_n && result_valid && result_ready)
            sb.check_result(result);

    function automatic logic [POP_BITS-1:0] pop(input count_t a, input count_t t,
                                                 input count_t c, input count_t g,
                                                 input count_t n, input count_t indel);
        return {a, t, c, g, n, indel};
    endfunction

    function automatic count_t rand_count();
        count_t v;
        case ($urandom_range(0, 3))
            0:       v = count_t'($urandom_range(1, 15));
            1:       v = '1;
            default: v = count_t'($urandom);
        endcase
        if (v == 0)
            v = 1;
        return v;
    endfunction

    function automatic logic [POP_BITS-1:0] rand_pop(input int nz);
        logic [POP_BITS-1:0] v;
        bit [ALLELES-1:0]    used;
        int                  k, slot;
        v    = '0;
        used = '0;
        k    = 0;
        while (k < nz)
        begin
            slot = $urandom_range(0, ALLELES - 1);
            if (!used[slot])
            begin
                used[slot] = 1'b1;
                v[POP_BITS-1-COUNT_BITS*slot -: COUNT_BITS] = rand_count();
                k++;
            end
        end
        return v;
    endfunction

    // mostly sites that pass the allele filter, the rest arbitrary
    function automatic site_t next_random_site();
        int n1, n2;
        if ($urandom_range(0, 4) == 0)
            return {rand_pop($urandom_range(0, ALLELES)), rand_pop($urandom_range(0, ALLELES))};
        n1 = $urandom_range(1, 2);
        n2 = (n1 == 1) ? 2 : $urandom_range(1, 2);
        return {rand_pop(n1), rand_pop(n2)};
    endfunction

    task send_site(input site_t s);
        site_valid <= 1'b1;
        site       <= s;
        do
            @(posedge clk);
        while (!site_ready);
        sb.note_site(s);
    endtask

    task send_directed(input logic [POP_BITS-1:0] p1, input logic [POP_BITS-1:0] p2);
        send_site({p1, p2});
        directed++;
    endtask

    task drain_results();
        site_valid <= 1'b0;
        while (sb.pending_count() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        sb = new;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_directed('0, '0);
        send_directed('1, '1);
        send_directed(pop(7, 0, 0, 0, 0, 0), pop(3, 0, 0, 0, 0, 0));
        send_directed(pop(10, 30, 0, 0, 0, 0), pop(5, 0, 0, 0, 0, 0));
        send_directed('0, pop(0, 4, 0, 9, 0, 0));
        send_directed(pop(1, 2, 3, 0, 0, 0), pop(4, 5, 0, 0, 0, 0));
        send_directed(pop(0, 7, 9, 0, 0, 0), pop(3, 1, 0, 0, 0, 0));
        send_directed(pop(5, 5, 0, 0, 0, 0), pop(0, 0, 0, 100, 0, 0));
        send_directed(pop('1, '1, 0, 0, 0, 0), pop('1, 0, 0, 1, 0, 0));
        send_directed(pop(0, 0, 50, 0, 0, 0), pop(0, 0, 1, '1, 0, 0));
        send_directed(pop(0, 0, 0, 9, 0, 0), pop(0, 0, 0, 0, 4, 2));
        send_directed(pop(1, 2, 0, 0, 0, 0), pop(2, 1, 0, 0, 0, 0));
        send_directed(pop(0, 1, 0, 1, 0, 0), pop(0, 1, 0, 0, 0, 0));
        send_directed(pop(16'hAAAA, 0, 16'h5555, 0, 0, 0),
                      pop(16'h5555, 0, 16'hAAAA, 0, 0, 0));
        send_directed(pop(0, 0, 0, 0, 3, 1), pop(0, 0, 0, 0, 2, 2));
        send_directed(pop(0, 0, 0, 0, '1, '1), pop(0, 0, 0, 0, 0, 1));
        send_directed(pop(0, 0, 0, 0, 0, 8), pop(1, 1, 1, 1, 1, 1));
        send_directed(pop(40, 0, 0, 0, 0, 20), pop(40, 0, 0, 0, 0, 20));
        send_directed(pop(0, 0, 0, 0, 0, 6), pop(0, 0, 0, 0, 0, 2));
        drain_results();

        idle_odds = 6;
        for (int k = 0; k < RANDOM_SITES; k++)
        begin
            if (k == 600)
                idle_odds = 0;
            if (k == 750)
                idle_odds = 6;
            if (k == 900)
                drain_results();
            if (k == RANDOM_SITES - 300)
                idle_odds = 0;
            if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0)
            begin
                site_valid <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            send_site(next_random_site());
        end
        drain_results();
        repeat (3 * LATENCY) @(posedge clk);

        $display("Sent %0d sites (%0d directed): %0d passed the allele filter, %0d dropped",
                 sb.kept + sb.dropped, directed, sb.kept, sb.dropped);
        $display("Compared %0d result beats, %0d mismatches", sb.checked, sb.fails);
        if (sb.fails == 0 && sb.pending_count() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
